// ----- hw/rtl/spi_mbe_pkg.sv -----
package spi_mbe_pkg;

    localparam int WordBitsDefault = 8;
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 16;
    localparam int DelayW = 16;
    localparam logic [DelayW-1:0] DelayReset = 16'd1024;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_RECV = 2'd2
    } op_t;

    localparam logic [CfgIdxW-1:0] CFG_DELAY_TICKS = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_MSB_FIRST   = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_USE_CS      = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_FOUR_WIRE   = 8'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PRE_SCLK = 4'd1,
        PH_PRE_CS   = 4'd2,
        PH_PRE_CD   = 4'd3,
        PH_BIT_DATA = 4'd4,
        PH_BIT_LOW  = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_POST_CD  = 4'd7,
        PH_POST_CS  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [DelayW-1:0] delay_ticks;
        logic              msb_first;
        logic              use_cs;
        logic              four_wire;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       cmd_sel;
        logic       write_only;
        logic       miso_level;
    } item_t;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       cs_n;
        logic       cd;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rejected;
    } result_t;

endpackage

// ----- hw/rtl/spi_mbe_if.sv -----
interface spi_mbe_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       cmd_sel;
    logic       write_only;
    logic       miso_level;

    modport source (
        output valid, operation, tx_byte, last_byte, cmd_sel, write_only, miso_level,
        input  ready
    );
    modport sink (
        input  valid, operation, tx_byte, last_byte, cmd_sel, write_only, miso_level,
        output ready
    );
endinterface

interface spi_mbe_res_if;
    logic       valid;
    logic       ready;
    logic       sclk;
    logic       mosi;
    logic       cs_n;
    logic       cd;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rejected;

    modport source (
        output valid, sclk, mosi, cs_n, cd, busy_res, rx_valid, rx_byte, rejected,
        input  ready
    );
    modport sink (
        input  valid, sclk, mosi, cs_n, cd, busy_res, rx_valid, rx_byte, rejected,
        output ready
    );
endinterface

interface spi_mbe_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spi_mbe_pkg::CfgIdxW-1:0]   index;
    logic [spi_mbe_pkg::CfgDataW-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/spi_master_bit_engine.sv -----
// SPI master bit engine, clock idling high; one result beat per command beat.
// Path: input register, then result register; the core updates its phase
// state in the same step that loads the result register.
// Throughput: one beat per cycle unless a held result (res.ready low) stalls.
// Reset (rst_n, async, active low): core idle, pins high, cfg regs at defaults.
module spi_master_bit_engine #(
    parameter int WORD_BITS = spi_mbe_pkg::WordBitsDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    spi_mbe_cfg_if.sink    cfg,
    spi_mbe_cmd_if.sink    cmd,
    spi_mbe_res_if.source  res
);

    spi_mbe_pkg::cfg_t    regs;
    spi_mbe_pkg::item_t   item_reg, item_next;
    spi_mbe_pkg::result_t result, result_reg;
    logic                 in_vld_reg, in_vld_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 adv;
    logic                 step;

    spi_mbe_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    spi_mbe_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .step   (step),
        .item   (item_reg),
        .result (result)
    );

    assign adv       = !out_vld_reg || res.ready;
    assign step      = in_vld_reg && adv;
    assign cmd.ready = !in_vld_reg || adv;

    always_comb
    begin
        item_next.operation  = cmd.operation;
        item_next.tx_byte    = cmd.tx_byte;
        item_next.last_byte  = cmd.last_byte;
        item_next.cmd_sel    = cmd.cmd_sel;
        item_next.write_only = cmd.write_only;
        item_next.miso_level = cmd.miso_level;
        in_vld_next  = cmd.ready ? cmd.valid : in_vld_reg;
        out_vld_next = adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
            item_reg <= item_next;
        if (step)
            result_reg <= result;
    end

    assign res.valid    = out_vld_reg;
    assign res.sclk     = result_reg.sclk;
    assign res.mosi     = result_reg.mosi;
    assign res.cs_n     = result_reg.cs_n;
    assign res.cd       = result_reg.cd;
    assign res.busy_res = result_reg.busy_res;
    assign res.rx_valid = result_reg.rx_valid;
    assign res.rx_byte  = result_reg.rx_byte;
    assign res.rejected = result_reg.rejected;

endmodule

// ----- hw/rtl/spi_mbe_cfg.sv -----
module spi_mbe_cfg (
    input  logic                clk,
    input  logic                rst_n,
    spi_mbe_cfg_if.sink         cfg,
    output spi_mbe_pkg::cfg_t   regs
);

    spi_mbe_pkg::cfg_t regs_reg;
    spi_mbe_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                spi_mbe_pkg::CFG_DELAY_TICKS:
                    regs_next.delay_ticks = cfg.data[spi_mbe_pkg::DelayW-1:0];
                spi_mbe_pkg::CFG_MSB_FIRST:
                    regs_next.msb_first = cfg.data[0];
                spi_mbe_pkg::CFG_USE_CS:
                    regs_next.use_cs = cfg.data[0];
                spi_mbe_pkg::CFG_FOUR_WIRE:
                    regs_next.four_wire = cfg.data[0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.delay_ticks <= spi_mbe_pkg::DelayReset;
            regs_reg.msb_first   <= 1'b1;
            regs_reg.use_cs      <= 1'b1;
            regs_reg.four_wire   <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hw/rtl/spi_mbe_core.sv -----
module spi_mbe_core #(
    parameter int WORD_BITS = spi_mbe_pkg::WordBitsDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spi_mbe_pkg::cfg_t      regs,
    input  logic                   step,
    input  spi_mbe_pkg::item_t     item,
    output spi_mbe_pkg::result_t   result
);

    localparam int BiW  = $clog2(WORD_BITS + 1);
    localparam int PosW = $clog2(WORD_BITS);
    localparam int ExtW = (WORD_BITS > 8) ? WORD_BITS : 8;
    localparam int DW   = spi_mbe_pkg::DelayW;

    spi_mbe_pkg::phase_t phase_reg, phase_next, act_phase, seq_phase;
    logic [DW-1:0]        wait_reg, wait_next, wait_dec;
    logic [BiW-1:0]       bit_index_reg, bit_index_next, pos_full;
    logic [PosW-1:0]      pos;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [ExtW-1:0]      shift_ext;
    logic                 in_trans_reg, in_trans_next;
    logic                 cd_handled_reg, cd_handled_next;
    logic                 recv_reg, recv_next;
    logic                 last_reg, last_next;
    logic                 cd_pending_reg, cd_pending_next;
    logic                 cd_level_reg, cd_level_next;
    logic                 sclk_reg, sclk_next;
    logic                 mosi_reg, mosi_next;
    logic                 cs_n_reg, cs_n_next;
    logic                 cd_reg, cd_next;
    logic                 do_act, rej, rxv;
    logic                 is_byte_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= spi_mbe_pkg::PH_IDLE;
            wait_reg       <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            in_trans_reg   <= 1'b0;
            cd_handled_reg <= 1'b0;
            recv_reg       <= 1'b0;
            last_reg       <= 1'b0;
            cd_pending_reg <= 1'b0;
            cd_level_reg   <= 1'b0;
            sclk_reg       <= 1'b1;
            mosi_reg       <= 1'b1;
            cs_n_reg       <= 1'b1;
            cd_reg         <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            wait_reg       <= wait_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            in_trans_reg   <= in_trans_next;
            cd_handled_reg <= cd_handled_next;
            recv_reg       <= recv_next;
            last_reg       <= last_next;
            cd_pending_reg <= cd_pending_next;
            cd_level_reg   <= cd_level_next;
            sclk_reg       <= sclk_next;
            mosi_reg       <= mosi_next;
            cs_n_reg       <= cs_n_next;
            cd_reg         <= cd_next;
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            spi_mbe_pkg::PH_PRE_SCLK:
                seq_phase = regs.use_cs ? spi_mbe_pkg::PH_PRE_CS
                          : (cd_pending_reg ? spi_mbe_pkg::PH_PRE_CD
                                            : spi_mbe_pkg::PH_BIT_DATA);
            spi_mbe_pkg::PH_PRE_CS:
                seq_phase = cd_pending_reg ? spi_mbe_pkg::PH_PRE_CD
                                           : spi_mbe_pkg::PH_BIT_DATA;
            spi_mbe_pkg::PH_PRE_CD:
                seq_phase = spi_mbe_pkg::PH_BIT_DATA;
            spi_mbe_pkg::PH_BIT_DATA:
                seq_phase = spi_mbe_pkg::PH_BIT_LOW;
            spi_mbe_pkg::PH_BIT_LOW:
                seq_phase = spi_mbe_pkg::PH_BIT_HIGH;
            spi_mbe_pkg::PH_BIT_HIGH:
                if (bit_index_reg < BiW'(WORD_BITS))
                    seq_phase = spi_mbe_pkg::PH_BIT_DATA;
                else if (!last_reg)
                    seq_phase = spi_mbe_pkg::PH_IDLE;
                else if (cd_handled_reg)
                    seq_phase = spi_mbe_pkg::PH_POST_CD;
                else
                    seq_phase = regs.use_cs ? spi_mbe_pkg::PH_POST_CS : spi_mbe_pkg::PH_IDLE;
            spi_mbe_pkg::PH_POST_CD:
                seq_phase = regs.use_cs ? spi_mbe_pkg::PH_POST_CS : spi_mbe_pkg::PH_IDLE;
            default:
                seq_phase = spi_mbe_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        in_trans_next   = in_trans_reg;
        cd_handled_next = cd_handled_reg;
        recv_next       = recv_reg;
        last_next       = last_reg;
        cd_pending_next = cd_pending_reg;
        cd_level_next   = cd_level_reg;
        sclk_next       = sclk_reg;
        mosi_next       = mosi_reg;
        cs_n_next       = cs_n_reg;
        cd_next         = cd_reg;
        rej             = 1'b0;
        rxv             = 1'b0;
        do_act          = 1'b0;
        act_phase       = spi_mbe_pkg::PH_IDLE;
        wait_dec        = (wait_reg == '0) ? '0 : wait_reg - DW'(1);
        is_byte_cmd     = (item.operation == spi_mbe_pkg::OP_SEND)
                       || (item.operation == spi_mbe_pkg::OP_RECV);

        if (is_byte_cmd)
        begin
            if (phase_reg != spi_mbe_pkg::PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                recv_next       = (item.operation == spi_mbe_pkg::OP_RECV);
                last_next       = item.last_byte;
                cd_pending_next = !in_trans_reg && regs.four_wire && item.write_only;
                cd_level_next   = !item.cmd_sel;
                shift_next      = recv_next ? '0
                                : WORD_BITS'(ExtW'(item.tx_byte));
                bit_index_next  = '0;
                in_trans_next   = 1'b1;
                do_act          = 1'b1;
                act_phase       = in_trans_reg ? spi_mbe_pkg::PH_BIT_DATA
                                               : spi_mbe_pkg::PH_PRE_SCLK;
            end
        end
        else if (phase_reg != spi_mbe_pkg::PH_IDLE)
        begin
            wait_next = wait_dec;
            if (wait_dec == '0)
            begin
                rxv = (phase_reg == spi_mbe_pkg::PH_BIT_HIGH)
                   && (bit_index_reg >= BiW'(WORD_BITS)) && recv_reg;
                if (seq_phase == spi_mbe_pkg::PH_IDLE)
                begin
                    phase_next = spi_mbe_pkg::PH_IDLE;
                    if (last_reg)
                    begin
                        in_trans_next   = 1'b0;
                        cd_handled_next = 1'b0;
                    end
                end
                else
                begin
                    do_act    = 1'b1;
                    act_phase = seq_phase;
                end
            end
        end

        pos_full = regs.msb_first ? BiW'(WORD_BITS - 1) - bit_index_next : bit_index_next;
        pos      = pos_full[PosW-1:0];

        if (do_act)
        begin
            phase_next = act_phase;
            wait_next  = (regs.delay_ticks == '0) ? DW'(1) : regs.delay_ticks;
            unique case (act_phase)
                spi_mbe_pkg::PH_PRE_SCLK:
                begin
                    sclk_next = 1'b1;
                    if (!recv_next)
                        mosi_next = 1'b0;
                end
                spi_mbe_pkg::PH_PRE_CS:
                    cs_n_next = 1'b0;
                spi_mbe_pkg::PH_PRE_CD:
                begin
                    cd_next         = cd_level_next;
                    cd_handled_next = 1'b1;
                end
                spi_mbe_pkg::PH_BIT_DATA:
                begin
                    if (recv_next)
                    begin
                        if (item.miso_level)
                            shift_next[pos] = 1'b1;
                    end
                    else
                    begin
                        mosi_next = shift_next[pos];
                    end
                end
                spi_mbe_pkg::PH_BIT_LOW:
                    sclk_next = 1'b0;
                spi_mbe_pkg::PH_BIT_HIGH:
                begin
                    sclk_next      = 1'b1;
                    bit_index_next = bit_index_next + BiW'(1);
                end
                spi_mbe_pkg::PH_POST_CD:
                    cd_next = 1'b1;
                spi_mbe_pkg::PH_POST_CS:
                    cs_n_next = 1'b1;
                default:
                    phase_next = act_phase;
            endcase
        end
    end

    assign shift_ext = ExtW'(shift_reg);

    always_comb
    begin
        result.sclk     = sclk_next;
        result.mosi     = mosi_next;
        result.cs_n     = cs_n_next;
        result.cd       = cd_next;
        result.busy_res = (phase_next != spi_mbe_pkg::PH_IDLE);
        result.rx_valid = rxv;
        result.rx_byte  = rxv ? shift_ext[7:0] : 8'd0;
        result.rejected = rej;
    end

endmodule

// ----- bench/spi_master_bit_engine_tb.sv -----
module spi_master_bit_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = spi_mbe_pkg::WordBitsDefault;
    localparam int CIW = spi_mbe_pkg::CfgIdxW;
    localparam int CDW = spi_mbe_pkg::CfgDataW;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic clk;
    logic rst_n;

    spi_mbe_cfg_if cfg_bus ();
    spi_mbe_cmd_if cmd_bus ();
    spi_mbe_res_if res_bus ();

    spi_master_bit_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    // engine copy
    int unsigned         cfg_delay;
    logic                cfg_msb;
    logic                cfg_cs;
    logic                cfg_4w;
    spi_mbe_pkg::phase_t eng_phase;
    int unsigned         wait_left;
    int unsigned         bit_pos;
    logic [WB-1:0]       shreg;
    logic                in_xact;
    logic                cd_done;
    logic                byte_rx;
    logic                byte_last;
    logic                cd_due;
    logic                cd_drive;
    logic                pin_sclk;
    logic                pin_mosi;
    logic                pin_cs_n;
    logic                pin_cd;

    spi_mbe_pkg::result_t exp_pins[$];
    int                   err_count;
    int                   beat_no;
    int                   burst_left;
    bit                   gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[%0t] beat %0d %s: got %0d want %0d", $realtime, beat_no, what, got, want);
        err_count++;
    endtask

    function automatic void do_action(input spi_mbe_pkg::phase_t p, input logic miso);
        int pos;
        eng_phase = p;
        wait_left = (cfg_delay == 0) ? 1 : cfg_delay;
        case (p)
            spi_mbe_pkg::PH_PRE_SCLK:
            begin
                pin_sclk = 1'b1;
                if (!byte_rx)
                    pin_mosi = 1'b0;
            end
            spi_mbe_pkg::PH_PRE_CS: pin_cs_n = 1'b0;
            spi_mbe_pkg::PH_PRE_CD:
            begin
                pin_cd = cd_drive;
                cd_done = 1'b1;
            end
            spi_mbe_pkg::PH_BIT_DATA:
            begin
                pos = cfg_msb ? (WB - 1 - bit_pos) : bit_pos;
                if (byte_rx)
                begin
                    if (miso)
                        shreg[pos] = 1'b1;
                end
                else
                    pin_mosi = shreg[pos];
            end
            spi_mbe_pkg::PH_BIT_LOW: pin_sclk = 1'b0;
            spi_mbe_pkg::PH_BIT_HIGH:
            begin
                pin_sclk = 1'b1;
                bit_pos++;
            end
            spi_mbe_pkg::PH_POST_CD: pin_cd = 1'b1;
            spi_mbe_pkg::PH_POST_CS: pin_cs_n = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic spi_mbe_pkg::result_t predict_step(input spi_mbe_pkg::item_t it);
        spi_mbe_pkg::result_t r;
        spi_mbe_pkg::phase_t  nxt;
        logic                 rej;
        logic                 rxv;
        rej = 1'b0;
        rxv = 1'b0;
        if (it.operation == spi_mbe_pkg::OP_SEND || it.operation == spi_mbe_pkg::OP_RECV)
        begin
            if (eng_phase != spi_mbe_pkg::PH_IDLE)
                rej = 1'b1;
            else
            begin
                byte_rx = (it.operation == spi_mbe_pkg::OP_RECV);
                byte_last = it.last_byte;
                cd_due = !in_xact && cfg_4w && it.write_only;
                cd_drive = !it.cmd_sel;
                shreg = byte_rx ? '0 : WB'(it.tx_byte);
                bit_pos = 0;
                nxt = in_xact ? spi_mbe_pkg::PH_BIT_DATA : spi_mbe_pkg::PH_PRE_SCLK;
                in_xact = 1'b1;
                do_action(nxt, it.miso_level);
            end
        end
        else if (eng_phase != spi_mbe_pkg::PH_IDLE)
        begin
            if (wait_left > 0)
                wait_left--;
            if (wait_left == 0)
            begin
                rxv = (eng_phase == spi_mbe_pkg::PH_BIT_HIGH) && (bit_pos >= WB) && byte_rx;
                case (eng_phase)
                    spi_mbe_pkg::PH_PRE_SCLK:
                        nxt = cfg_cs ? spi_mbe_pkg::PH_PRE_CS
                            : (cd_due ? spi_mbe_pkg::PH_PRE_CD : spi_mbe_pkg::PH_BIT_DATA);
                    spi_mbe_pkg::PH_PRE_CS:
                        nxt = cd_due ? spi_mbe_pkg::PH_PRE_CD : spi_mbe_pkg::PH_BIT_DATA;
                    spi_mbe_pkg::PH_PRE_CD: nxt = spi_mbe_pkg::PH_BIT_DATA;
                    spi_mbe_pkg::PH_BIT_DATA: nxt = spi_mbe_pkg::PH_BIT_LOW;
                    spi_mbe_pkg::PH_BIT_LOW: nxt = spi_mbe_pkg::PH_BIT_HIGH;
                    spi_mbe_pkg::PH_BIT_HIGH:
                    begin
                        if (bit_pos < WB)
                            nxt = spi_mbe_pkg::PH_BIT_DATA;
                        else if (!byte_last)
                            nxt = spi_mbe_pkg::PH_IDLE;
                        else if (cd_done)
                            nxt = spi_mbe_pkg::PH_POST_CD;
                        else
                            nxt = cfg_cs ? spi_mbe_pkg::PH_POST_CS : spi_mbe_pkg::PH_IDLE;
                    end
                    spi_mbe_pkg::PH_POST_CD:
                        nxt = cfg_cs ? spi_mbe_pkg::PH_POST_CS : spi_mbe_pkg::PH_IDLE;
                    default: nxt = spi_mbe_pkg::PH_IDLE;
                endcase
                if (nxt == spi_mbe_pkg::PH_IDLE)
                begin
                    eng_phase = spi_mbe_pkg::PH_IDLE;
                    if (byte_last)
                    begin
                        in_xact = 1'b0;
                        cd_done = 1'b0;
                    end
                end
                else
                    do_action(nxt, it.miso_level);
            end
        end
        r.sclk = pin_sclk;
        r.mosi = pin_mosi;
        r.cs_n = pin_cs_n;
        r.cd = pin_cd;
        r.busy_res = (eng_phase != spi_mbe_pkg::PH_IDLE);
        r.rx_valid = rxv;
        r.rx_byte = rxv ? shreg[7:0] : 8'd0;
        r.rejected = rej;
        return r;
    endfunction

    function automatic spi_mbe_pkg::item_t make_item(input logic [1:0] op, input logic [7:0] tx,
                                                     input logic last, input logic is_cmd,
                                                     input logic wonly, input logic miso);
        spi_mbe_pkg::item_t it;
        it.operation = op;
        it.tx_byte = tx;
        it.last_byte = last;
        it.cmd_sel = is_cmd;
        it.write_only = wonly;
        it.miso_level = miso;
        return it;
    endfunction

    function automatic spi_mbe_pkg::item_t noise_tick(input logic [1:0] op, input logic miso);
        return make_item(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), miso);
    endfunction

    task automatic push_beat(input spi_mbe_pkg::item_t it);
        if (gaps_on && burst_left == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        cmd_bus.valid <= 1'b1;
        cmd_bus.operation <= it.operation;
        cmd_bus.tx_byte <= it.tx_byte;
        cmd_bus.last_byte <= it.last_byte;
        cmd_bus.cmd_sel <= it.cmd_sel;
        cmd_bus.write_only <= it.write_only;
        cmd_bus.miso_level <= it.miso_level;
        do @(posedge clk); while (!cmd_bus.ready);
        exp_pins.push_back(predict_step(it));
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
        cmd_bus.valid <= 1'b0;
        while (exp_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            spi_mbe_pkg::CFG_DELAY_TICKS: cfg_delay = val;
            spi_mbe_pkg::CFG_MSB_FIRST: cfg_msb = val[0];
            spi_mbe_pkg::CFG_USE_CS: cfg_cs = val[0];
            spi_mbe_pkg::CFG_FOUR_WIRE: cfg_4w = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int delay, input logic msb, input logic cs, input logic fw);
        write_reg(spi_mbe_pkg::CFG_DELAY_TICKS, CDW'(delay));
        write_reg(spi_mbe_pkg::CFG_MSB_FIRST, CDW'(msb));
        write_reg(spi_mbe_pkg::CFG_USE_CS, CDW'(cs));
        write_reg(spi_mbe_pkg::CFG_FOUR_WIRE, CDW'(fw));
    endtask

    // miso_mode: 0 low, 1 high, otherwise random
    task automatic finish_byte(input int miso_mode, input bit poke);
        int   n;
        logic miso;
        n = 0;
        while (eng_phase != spi_mbe_pkg::PH_IDLE)
        begin
            miso = (miso_mode == 0) ? 1'b0 : (miso_mode == 1) ? 1'b1 : 1'($urandom);
            if (poke && n == 5)
            begin
                push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'h5A, 1'b1, 1'b1, 1'b1, miso));
                push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'hFF, 1'b0, 1'b0, 1'b0, miso));
                push_beat(noise_tick(OP_SPARE, miso));
            end
            else
                push_beat(noise_tick(spi_mbe_pkg::OP_TICK, miso));
            n++;
        end
    endtask

    task automatic test_idle_ticks();
        push_beat(noise_tick(spi_mbe_pkg::OP_TICK, 1'b0));
        push_beat(noise_tick(OP_SPARE, 1'b1));
        push_beat(noise_tick(spi_mbe_pkg::OP_TICK, 1'b1));
    endtask

    task automatic test_directed_bytes();
        set_regs(0, 1'b1, 1'b1, 1'b1);
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        finish_byte(2, 1'b1);
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
        finish_byte(2, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1));
        finish_byte(1, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        finish_byte(0, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'h81, 1'b1, 1'b0, 1'b0, 1'b1));
        finish_byte(2, 1'b0);
        write_reg(spi_mbe_pkg::CFG_MSB_FIRST, CDW'(0));
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'hA5, 1'b1, 1'b0, 1'b1, 1'b0));
        finish_byte(2, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
        finish_byte(2, 1'b0);
        set_regs(1, 1'b1, 1'b0, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'h3C, 1'b0, 1'b1, 1'b1, 1'b0));
        finish_byte(2, 1'b0);
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'hC3, 1'b1, 1'b0, 1'b1, 1'b1));
        finish_byte(2, 1'b0);
        set_regs(2, 1'b1, 1'b1, 1'b1);
        push_beat(make_item(spi_mbe_pkg::OP_RECV, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
        finish_byte(2, 1'b0);
    endtask

    task automatic test_long_delay();
        write_reg(spi_mbe_pkg::CFG_DELAY_TICKS, 16'hFFFF);
        test_idle_ticks();
        set_regs(3, 1'b1, 1'b1, 1'b1);
        push_beat(make_item(spi_mbe_pkg::OP_SEND, 8'h96, 1'b1, 1'b1, 1'b1, 1'b0));
        finish_byte(2, 1'b1);
    endtask

    task automatic test_random_traffic();
        int         counted;
        int         xact_left;
        int         pick;
        logic [1:0] op;
        logic       last;
        logic       wonly;
        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0: set_regs(1, 1'b1, 1'b1, 1'b1);
                1: set_regs(2, 1'b0, 1'b1, 1'b1);
                2: set_regs(0, 1'b1, 1'b0, 1'b1);
                3: set_regs(3, 1'b0, 1'b0, 1'b0);
                default: set_regs($urandom_range(0, 4), 1'($urandom), 1'($urandom),
                                  1'($urandom));
            endcase
            gaps_on = (setting != 2);
            counted = 0;
            xact_left = 0;
            while (counted < 20)
            begin
                if (eng_phase == spi_mbe_pkg::PH_IDLE)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_beat(noise_tick($urandom_range(0, 1) ? OP_SPARE
                                                                  : spi_mbe_pkg::OP_TICK,
                                             1'($urandom)));
                    else
                    begin
                        if (!in_xact)
                            xact_left = $urandom_range(1, 3);
                        else if (xact_left == 0)
                            xact_left = 1;
                        last = (xact_left == 1);
                        if ($urandom_range(0, 11) == 0)
                            last = ~last;
                        op = $urandom_range(0, 1) ? spi_mbe_pkg::OP_SEND : spi_mbe_pkg::OP_RECV;
                        wonly = (op == spi_mbe_pkg::OP_SEND) ? ($urandom_range(0, 3) != 0)
                                                             : ($urandom_range(0, 3) == 0);
                        push_beat(make_item(op, 8'($urandom), last, 1'($urandom), wonly,
                                            1'($urandom)));
                        if (xact_left > 0)
                            xact_left--;
                        counted++;
                    end
                end
                else
                begin
                    pick = $urandom_range(0, 31);
                    op = (pick == 0) ? spi_mbe_pkg::OP_SEND : (pick == 1) ? spi_mbe_pkg::OP_RECV :
                         (pick == 2) ? OP_SPARE : spi_mbe_pkg::OP_TICK;
                    push_beat(noise_tick(op, 1'($urandom)));
                    counted++;
                end
            end
            finish_byte(2, 1'b0);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int sink_mode;
        int sink_span;
        int sink_count;
        sink_span = 0;
        sink_count = 0;
        sink_mode = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_span == 0)
            begin
                sink_mode = $urandom_range(0, 3);
                sink_span = $urandom_range(16, 160);
            end
            sink_span--;
            sink_count++;
            case (sink_mode)
                0: res_bus.ready <= 1'b1;
                1: res_bus.ready <= 1'($urandom);
                2: res_bus.ready <= (sink_count % 4 == 0);
                default: res_bus.ready <= (sink_count % 16) < 11;
            endcase
        end
    end

    always @(posedge clk)
    begin
        spi_mbe_pkg::result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            beat_no++;
            if (exp_pins.size() == 0)
                note_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = exp_pins.pop_front();
                if (res_bus.sclk !== want.sclk)
                    note_mismatch("sclk", res_bus.sclk, want.sclk);
                if (res_bus.mosi !== want.mosi)
                    note_mismatch("mosi", res_bus.mosi, want.mosi);
                if (res_bus.cs_n !== want.cs_n)
                    note_mismatch("cs_n", res_bus.cs_n, want.cs_n);
                if (res_bus.cd !== want.cd)
                    note_mismatch("cd", res_bus.cd, want.cd);
                if (res_bus.busy_res !== want.busy_res)
                    note_mismatch("busy_res", res_bus.busy_res, want.busy_res);
                if (res_bus.rx_valid !== want.rx_valid)
                    note_mismatch("rx_valid", res_bus.rx_valid, want.rx_valid);
                if (res_bus.rx_byte !== want.rx_byte)
                    note_mismatch("rx_byte", res_bus.rx_byte, want.rx_byte);
                if (res_bus.rejected !== want.rejected)
                    note_mismatch("rejected", res_bus.rejected, want.rejected);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        cfg_delay = spi_mbe_pkg::DelayReset;
        cfg_msb = 1'b1;
        cfg_cs = 1'b1;
        cfg_4w = 1'b0;
        eng_phase = spi_mbe_pkg::PH_IDLE;
        wait_left = 0;
        bit_pos = 0;
        shreg = '0;
        in_xact = 1'b0;
        cd_done = 1'b0;
        byte_rx = 1'b0;
        byte_last = 1'b0;
        cd_due = 1'b0;
        cd_drive = 1'b0;
        pin_sclk = 1'b1;
        pin_mosi = 1'b1;
        pin_cs_n = 1'b1;
        pin_cd = 1'b1;
        err_count = 0;
        beat_no = 0;
        burst_left = 0;
        gaps_on = 1'b1;

        rst_n <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.operation <= spi_mbe_pkg::OP_TICK;
        cmd_bus.tx_byte <= '0;
        cmd_bus.last_byte <= 1'b0;
        cmd_bus.cmd_sel <= 1'b0;
        cmd_bus.write_only <= 1'b0;
        cmd_bus.miso_level <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_directed_bytes();
        test_long_delay();
        test_random_traffic();

        cmd_bus.valid <= 1'b0;
        while (exp_pins.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
